// ===== rtl/slrl_pkg.sv =====
// Shared types and constants for the sliding-log rate limiter.
package slrl_pkg;

  localparam int CLIENTS_DEF = 64;
  localparam int MAX_LOG_DEF = 128;

  localparam logic [7:0]  MAX_REQ_RST = 8'd100;
  localparam logic [11:0] WIN_S_RST   = 12'd60;

  localparam int WMS_W = 22;  // window in ms, 4095 * 1000 fits
  localparam logic [9:0] MS_PER_S = 10'd1000;

  // Reciprocal of 1000 scaled by 2^32, exact for dividends below 2^22.
  localparam logic [22:0] RECIP_1000 = 23'd4294968;
  localparam logic [48:0] RETRY_SAT_MS = 49'd4096000;
  localparam logic [11:0] RETRY_MAX = 12'd4095;
  localparam logic [11:0] RETRY_MIN = 12'd1;

  localparam logic CFG_MAX_REQUESTS   = 1'b0;
  localparam logic CFG_WINDOW_SECONDS = 1'b1;

  typedef struct packed {
    logic [7:0]       max_req;
    logic [WMS_W-1:0] win_ms;
    logic [47:0]      now_ms;
    logic [31:0]      client_addr;
  } req_t;

  typedef struct packed {
    logic        table_full;
    logic [11:0] retry_after_s;
    logic        allowed;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_POP_RD,
    ST_POP_CHK,
    ST_RT_MUL,
    ST_RT_FIN,
    ST_RESULT
  } back_state_t;

endpackage

// ===== rtl/slrl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module slrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/slrl_queue.sv =====
// Two-entry queue carrying requests, with their limits, from the front to the back.
module slrl_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  slrl_pkg::req_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output slrl_pkg::req_t pop_data
);
  import slrl_pkg::*;

  req_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign full      = (fill_r == 2'd2);
  assign not_empty = (fill_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

// ===== rtl/slrl_front.sv =====
// Front end: configuration registers, request intake and tagging with the current limits.
module slrl_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [11:0]    cfg_data,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [79:0]    in_tdata,
  input  logic           clearing,
  input  logic           q_full,
  output logic           q_push,
  output slrl_pkg::req_t q_data
);
  import slrl_pkg::*;

  logic [7:0]  max_req_r, max_req_nxt;
  logic [11:0] win_s_r, win_s_nxt;
  logic [21:0] win_prod;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full && !clearing;
  assign q_push    = in_tvalid && in_tready;

  // Window length in milliseconds is formed once per request here.
  assign win_prod = win_s_r * MS_PER_S;

  always_comb begin
    q_data.client_addr = in_tdata[31:0];
    q_data.now_ms      = in_tdata[79:32];
    q_data.win_ms      = win_prod[WMS_W-1:0];
    q_data.max_req     = max_req_r;
  end

  always_comb begin
    max_req_nxt = max_req_r;
    win_s_nxt   = win_s_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_REQUESTS:   max_req_nxt = cfg_data[7:0];
        CFG_WINDOW_SECONDS: win_s_nxt   = cfg_data;
        default:            max_req_nxt = max_req_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_req_r <= MAX_REQ_RST;
      win_s_r   <= WIN_S_RST;
    end else begin
      max_req_r <= max_req_nxt;
      win_s_r   <= win_s_nxt;
    end
  end
endmodule

// ===== rtl/slrl_back.sv =====
// Back end: client table scan, stamp expiry, admit or reject, result register.
module slrl_back #(
  parameter int CLIENTS = slrl_pkg::CLIENTS_DEF,
  parameter int MAX_LOG = slrl_pkg::MAX_LOG_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  output logic           clearing,
  input  logic           q_not_empty,
  input  slrl_pkg::req_t q_data,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [15:0]    out_tdata
);
  import slrl_pkg::*;

  localparam int EW    = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  localparam int SW    = $clog2(CLIENTS + 1);
  localparam int HW    = (MAX_LOG > 1) ? $clog2(MAX_LOG) : 1;
  localparam int CW    = $clog2(MAX_LOG + 1);
  localparam int LW    = (CW > 8) ? CW : 8;
  localparam int DEPTH = CLIENTS * MAX_LOG;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Entry word: key, count, head, newest stamp from the lowest bit up.
  localparam int K_LO  = 0;
  localparam int C_LO  = 32;
  localparam int H_LO  = C_LO + CW;
  localparam int N_LO  = H_LO + HW;
  localparam int EDW   = N_LO + 48;

  back_state_t state_r, state_nxt;

  logic [SW-1:0]  scan_r, scan_nxt;
  logic [EW-1:0]  chk_idx_r, chk_idx_nxt;
  logic           chk_vld_r, chk_vld_nxt;
  logic           hit_fnd_r, hit_fnd_nxt;
  logic           free_fnd_r, free_fnd_nxt;
  logic [EW-1:0]  hit_idx_r, hit_idx_nxt;
  logic [EW-1:0]  free_idx_r, free_idx_nxt;
  logic [EDW-1:0] hit_word_r, hit_word_nxt;
  logic [EW-1:0]  clr_r, clr_nxt;
  logic           out_vld_r, out_vld_nxt;

  req_t           req_r, req_nxt;
  logic [EW-1:0]  ent_r, ent_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [HW-1:0]  head_r, head_nxt;
  logic [47:0]    newest_r, newest_nxt;
  logic [48:0]    diff_r, diff_nxt;
  logic [44:0]    prod_r, prod_nxt;
  logic           sat_r, sat_nxt;
  res_t           res_r, res_nxt;
  res_t           out_r, out_nxt;

  logic           ent_we;
  logic [EW-1:0]  ent_waddr;
  logic [EDW-1:0] ent_wdata;
  logic [EDW-1:0] ent_rdata;
  logic           st_we;
  logic [AW-1:0]  st_waddr;
  logic [AW-1:0]  st_raddr;
  logic [47:0]    st_rdata;

  logic [CW-1:0]  sc_cnt;
  logic [47:0]    sc_newest;
  logic           sc_live;
  logic [48:0]    stamp_end;
  logic           stamp_exp;
  logic           lim_hit;
  logic [HW:0]    tail_sum;
  logic [HW-1:0]  tail_slot;
  logic [AW-1:0]  ent_base;
  logic [11:0]    quot;

  slrl_ram #(.WIDTH(EDW), .DEPTH(CLIENTS)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (scan_r[EW-1:0]),
    .rdata (ent_rdata)
  );

  slrl_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_stamp_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (req_r.now_ms),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign clearing   = (state_r == ST_CLEAR);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_r.table_full, out_r.retry_after_s, out_r.allowed};

  // An entry is live while it holds stamps and its newest one is inside the window.
  assign sc_cnt    = ent_rdata[C_LO +: CW];
  assign sc_newest = ent_rdata[N_LO +: 48];
  assign sc_live   = (sc_cnt != '0) &&
                     !(({1'b0, sc_newest} + 49'(req_r.win_ms)) < {1'b0, req_r.now_ms});

  assign ent_base  = AW'(ent_r) * AW'(MAX_LOG);
  assign st_raddr  = ent_base + AW'(head_r);
  assign tail_sum  = {1'b0, head_r} + (HW + 1)'(cnt_r);
  assign tail_slot = (tail_sum >= (HW + 1)'(MAX_LOG)) ?
                     HW'(tail_sum - (HW + 1)'(MAX_LOG)) : HW'(tail_sum);
  assign st_waddr  = ent_base + AW'(tail_slot);

  assign stamp_end = {1'b0, st_rdata} + 49'(req_r.win_ms);
  assign stamp_exp = stamp_end < {1'b0, req_r.now_ms};
  assign lim_hit   = (LW'(cnt_r) >= LW'(req_r.max_req)) || (cnt_r == CW'(MAX_LOG));
  assign quot      = prod_r[43:32];

  always_comb begin
    state_nxt    = state_r;
    scan_nxt     = scan_r;
    chk_idx_nxt  = chk_idx_r;
    chk_vld_nxt  = 1'b0;
    hit_fnd_nxt  = hit_fnd_r;
    free_fnd_nxt = free_fnd_r;
    hit_idx_nxt  = hit_idx_r;
    free_idx_nxt = free_idx_r;
    hit_word_nxt = hit_word_r;
    clr_nxt      = clr_r;
    out_vld_nxt  = out_vld_r;
    req_nxt      = req_r;
    ent_nxt      = ent_r;
    cnt_nxt      = cnt_r;
    head_nxt     = head_r;
    newest_nxt   = newest_r;
    diff_nxt     = diff_r;
    prod_nxt     = prod_r;
    sat_nxt      = sat_r;
    res_nxt      = res_r;
    out_nxt      = out_r;
    q_pop        = 1'b0;
    ent_we       = 1'b0;
    ent_waddr    = ent_r;
    ent_wdata    = {newest_r, head_r, cnt_r, req_r.client_addr};
    st_we        = 1'b0;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ent_we    = 1'b1;
        ent_waddr = clr_r;
        ent_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == EW'(CLIENTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_not_empty) begin
          q_pop        = 1'b1;
          req_nxt      = q_data;
          scan_nxt     = '0;
          hit_fnd_nxt  = 1'b0;
          free_fnd_nxt = 1'b0;
          res_nxt      = '0;
          if (q_data.max_req == 8'd0) begin
            res_nxt.retry_after_s = RETRY_MIN;
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_r < SW'(CLIENTS)) begin
          scan_nxt    = scan_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_r[EW-1:0];
        end
        if (chk_vld_r) begin
          if (sc_live) begin
            if (!hit_fnd_r && ent_rdata[K_LO +: 32] == req_r.client_addr) begin
              hit_fnd_nxt  = 1'b1;
              hit_idx_nxt  = chk_idx_r;
              hit_word_nxt = ent_rdata;
            end
          end else if (!free_fnd_r) begin
            free_fnd_nxt = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
          if (chk_idx_r == EW'(CLIENTS - 1)) begin
            state_nxt = ST_RESOLVE;
          end
        end
      end
      ST_RESOLVE: begin
        if (hit_fnd_r) begin
          ent_nxt    = hit_idx_r;
          cnt_nxt    = hit_word_r[C_LO +: CW];
          head_nxt   = hit_word_r[H_LO +: HW];
          newest_nxt = hit_word_r[N_LO +: 48];
          state_nxt  = ST_POP_RD;
        end else if (free_fnd_r) begin
          ent_nxt    = free_idx_r;
          cnt_nxt    = '0;
          head_nxt   = '0;
          newest_nxt = '0;
          state_nxt  = ST_POP_RD;
        end else begin
          res_nxt.table_full = 1'b1;
          state_nxt = ST_RESULT;
        end
      end
      ST_POP_RD: begin
        state_nxt = ST_POP_CHK;
      end
      ST_POP_CHK: begin
        if (cnt_r != '0 && stamp_exp) begin
          head_nxt  = (head_r == HW'(MAX_LOG - 1)) ? '0 : head_r + 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = ST_POP_RD;
        end else if (lim_hit) begin
          ent_we    = 1'b1;
          diff_nxt  = stamp_end - {1'b0, req_r.now_ms};
          state_nxt = ST_RT_MUL;
        end else begin
          st_we     = 1'b1;
          ent_we    = 1'b1;
          ent_wdata = {req_r.now_ms, head_r, cnt_r + 1'b1, req_r.client_addr};
          res_nxt.allowed = 1'b1;
          state_nxt = ST_RESULT;
        end
      end
      ST_RT_MUL: begin
        sat_nxt   = diff_r >= RETRY_SAT_MS;
        prod_nxt  = diff_r[21:0] * RECIP_1000;
        state_nxt = ST_RT_FIN;
      end
      ST_RT_FIN: begin
        if (sat_r) begin
          res_nxt.retry_after_s = RETRY_MAX;
        end else if (quot == 12'd0) begin
          res_nxt.retry_after_s = RETRY_MIN;
        end else begin
          res_nxt.retry_after_s = quot;
        end
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_vld_r || out_tready) begin
          out_nxt     = res_r;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      scan_r     <= '0;
      chk_idx_r  <= '0;
      chk_vld_r  <= 1'b0;
      hit_fnd_r  <= 1'b0;
      free_fnd_r <= 1'b0;
      clr_r      <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_r     <= scan_nxt;
      chk_idx_r  <= chk_idx_nxt;
      chk_vld_r  <= chk_vld_nxt;
      hit_fnd_r  <= hit_fnd_nxt;
      free_fnd_r <= free_fnd_nxt;
      clr_r      <= clr_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    hit_word_r <= hit_word_nxt;
    req_r      <= req_nxt;
    ent_r      <= ent_nxt;
    cnt_r      <= cnt_nxt;
    head_r     <= head_nxt;
    newest_r   <= newest_nxt;
    diff_r     <= diff_nxt;
    prod_r     <= prod_nxt;
    sat_r      <= sat_nxt;
    res_r      <= res_nxt;
    out_r      <= out_nxt;
  end
endmodule

// ===== rtl/sliding_log_rate_limiter_core.sv =====
// Flow: a request passes the table scan, a resolve step and the pop-read/pop-check pair,
// which repeats per expired stamp dropped, plus a multiply and finish step when a retry
// time is computed, then the result register; the table scan reads one entry a cycle.
// A limit of zero skips straight to the result, a full table goes there after the scan.
// Throughput: one request at a time in the back end; a two-entry queue lets the front
// accept while the back end works. Reset: synchronous, active low; afterwards a clearing
// pass empties the client table, and no request is accepted until it ends.
module sliding_log_rate_limiter_core #(
  parameter int CLIENTS = slrl_pkg::CLIENTS_DEF,
  parameter int MAX_LOG = slrl_pkg::MAX_LOG_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // client_addr[31:0], now_ms[79:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // allowed[0], retry_after_s[12:1], table_full[13], zero
);
  import slrl_pkg::*;

  logic clearing;
  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  req_t q_in;
  req_t q_out;

  slrl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  slrl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  slrl_back #(.CLIENTS(CLIENTS), .MAX_LOG(MAX_LOG)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .clearing    (clearing),
    .q_not_empty (q_not_empty),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );
endmodule

// ===== rtl/slrl_checker.sv =====
// Port-level checks on the result stream of the rate limiter.
module slrl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result transaction dropped or changed while stalled");

  a_admit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[12:1] == 12'd0 && !out_tdata[13])
    else $error("admitted request carries a retry time or full flag");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[13] |-> !out_tdata[0] && out_tdata[12:1] == 12'd0)
    else $error("table-full result is inconsistent");

  a_retry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] && !out_tdata[13] |-> out_tdata[12:1] != 12'd0)
    else $error("rate-limited result without a retry time");
endmodule

bind sliding_log_rate_limiter_core slrl_checker u_slrl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the sliding-log rate limiter core.
module tb_top;
  import slrl_pkg::*;

  localparam int NCLI = CLIENTS_DEF;
  localparam int NLOG = MAX_LOG_DEF;
  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_MAX_REQUESTS;
  logic [11:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  sliding_log_rate_limiter_core u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the client table and limiter settings.
  bit [7:0]  lim_max_req;
  bit [11:0] lim_win_s;
  bit [31:0] cli_key [NCLI];
  int        cli_cnt [NCLI];
  int        cli_head[NCLI];
  bit [63:0] cli_stamp[NCLI][NLOG];

  res_t verdict_q[$];
  int   errors, n_req, n_allowed, n_limited, n_full;
  int   idle_pct, stall_pct;
  bit   rx_hold;

  function automatic bit stamp_expired(bit [63:0] s, bit [63:0] now, bit [63:0] wms);
    return s + wms < now;
  endfunction

  function automatic res_t rate_decide(bit [31:0] addr, bit [47:0] now48);
    bit [63:0] now, wms, unblock, secs;
    int        lim, hit, fre;
    res_t      r;
    now = now48;
    wms = lim_win_s * 64'd1000;
    lim = (lim_max_req < NLOG) ? lim_max_req : NLOG;
    hit = NCLI;
    fre = NCLI;
    r = '0;
    if (lim == 0) begin
      r.retry_after_s = 12'd1;
      return r;
    end
    for (int e = 0; e < NCLI; e++) begin
      if (cli_cnt[e] != 0 &&
          !stamp_expired(cli_stamp[e][(cli_head[e] + cli_cnt[e] - 1) % NLOG], now, wms)) begin
        if (hit == NCLI && cli_key[e] == addr) hit = e;
      end else if (fre == NCLI) begin
        fre = e;
      end
    end
    if (hit == NCLI) begin
      if (fre == NCLI) begin
        r.table_full = 1'b1;
        return r;
      end
      hit = fre;
      cli_key[hit] = addr;
      cli_cnt[hit] = 0;
      cli_head[hit] = 0;
    end
    while (cli_cnt[hit] > 0 && stamp_expired(cli_stamp[hit][cli_head[hit]], now, wms)) begin
      cli_head[hit] = (cli_head[hit] + 1) % NLOG;
      cli_cnt[hit]--;
    end
    if (cli_cnt[hit] >= lim) begin
      unblock = cli_stamp[hit][cli_head[hit]] + wms;
      secs = 1;
      if (unblock > now) begin
        secs = (unblock - now) / 1000;
        if (secs == 0) secs = 1;
        if (secs > 4095) secs = 4095;
      end
      r.retry_after_s = secs[11:0];
      return r;
    end
    cli_stamp[hit][(cli_head[hit] + cli_cnt[hit]) % NLOG] = now;
    cli_cnt[hit]++;
    r.allowed = 1'b1;
    return r;
  endfunction

  // Offers one request; returns once the transaction has been accepted.
  task automatic send_req(bit [31:0] addr, bit [47:0] now, bit fixed = 0, res_t fexp = '0);
    res_t p;
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {now, addr};
    do @(posedge clk); while (!in_tready);
    p = rate_decide(addr, now);
    if (fixed && p != fexp)
      $display("%0t: MISMATCH in predictor, expected %h got %h", $time, fexp, p);
    if (fixed && p != fexp) errors++;
    verdict_q.insert(verdict_q.size(), p);
    n_req++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    wait (verdict_q.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, bit [11:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_MAX_REQUESTS) lim_max_req = val[7:0];
    else lim_win_s = val;
  endtask

  // Result checking against the oldest outstanding verdict.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        res_t x;
        x = verdict_q[0];
        verdict_q.delete(0);
        if (out_tdata !== {2'b00, x}) begin
          $display("%0t: result mismatch, expected %h actual %h", $time, {2'b00, x},
                   out_tdata);
          errors++;
        end
        if (x.allowed) n_allowed++;
        else if (x.table_full) n_full++;
        else n_limited++;
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
  end

  int quiet;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet);
      $display("sliding_log_rate_limiter_core verification failed");
      $finish;
    end
  end

  typedef struct {
    bit [31:0] addr;
    bit [47:0] now;
    bit        fixed;
    res_t      exp;
  } req_row_t;

  req_row_t dir_rows[$];
  localparam res_t OK_R   = '{table_full: 1'b0, retry_after_s: 12'd0, allowed: 1'b1};
  localparam res_t RT1_R  = '{table_full: 1'b0, retry_after_s: 12'd1, allowed: 1'b0};
  localparam res_t RTMX_R = '{table_full: 1'b0, retry_after_s: 12'd4095, allowed: 1'b0};

  task automatic add_row(bit [31:0] a, bit [47:0] n, bit f, res_t e);
    req_row_t row;
    row = '{a, n, f, e};
    dir_rows.insert(dir_rows.size(), row);
  endtask

  task automatic run_rows();
    foreach (dir_rows[i]) send_req(dir_rows[i].addr, dir_rows[i].now, dir_rows[i].fixed,
                                   dir_rows[i].exp);
    dir_rows.delete();
    drain();
  endtask

  initial begin
    bit [31:0] pool[6];
    bit [47:0] t;
    int        modes_idle[4];
    int        modes_stall[4];

    modes_idle  = '{0, 50, 0, 30};
    modes_stall = '{0, 0, 50, 30};
    lim_max_req = MAX_REQ_RST;
    lim_win_s   = WIN_S_RST;
    foreach (cli_cnt[e]) begin
      cli_cnt[e] = 0;
      cli_head[e] = 0;
    end
    idle_pct = 0;
    stall_pct = 0;
    rx_hold = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: defaults after reset, time extremes, time running backwards.
    add_row(32'h0, 48'h0, 1'b1, OK_R);
    add_row(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, OK_R);
    add_row(32'h0, 48'h0, 1'b0, '0);
    add_row(32'hFFFF_FFFF, 48'h0, 1'b0, '0);
    add_row(32'hA5A5_5A5A, 48'h5555_AAAA_5555, 1'b0, '0);
    run_rows();

    write_reg(CFG_MAX_REQUESTS, 12'd2);
    write_reg(CFG_WINDOW_SECONDS, 12'd1);
    add_row(32'h1234, 48'd1000000, 1'b1, OK_R);
    add_row(32'h1234, 48'd1000100, 1'b1, OK_R);
    add_row(32'h1234, 48'd1000200, 1'b1, RT1_R);
    add_row(32'h1234, 48'd1001001, 1'b1, OK_R);
    add_row(32'h1234, 48'd1001050, 1'b0, '0);
    run_rows();

    // A limit of zero rejects everything and stores nothing.
    write_reg(CFG_MAX_REQUESTS, 12'd0);
    add_row(32'h9999, 48'd2000000, 1'b1, RT1_R);
    add_row(32'h1234, 48'd2000000, 1'b1, RT1_R);
    run_rows();

    write_reg(CFG_MAX_REQUESTS, 12'd1);
    write_reg(CFG_WINDOW_SECONDS, 12'd4095);
    add_row(32'h77, 48'd5000000, 1'b1, OK_R);
    add_row(32'h77, 48'd5000000, 1'b1, RTMX_R);
    add_row(32'h78, 48'd5000001, 1'b0, '0);
    run_rows();

    write_reg(CFG_WINDOW_SECONDS, 12'd0);
    add_row(32'h77, 48'd5000002, 1'b0, '0);
    add_row(32'h77, 48'd5000002, 1'b0, '0);
    add_row(32'h77, 48'd5000003, 1'b0, '0);
    run_rows();

    // Random phases, one per idling mode.
    for (int m = 0; m < 4; m++) begin
      idle_pct  = modes_idle[m];
      stall_pct = modes_stall[m];
      write_reg(CFG_MAX_REQUESTS, 12'($urandom_range(6, 1)));
      write_reg(CFG_WINDOW_SECONDS, 12'($urandom_range(5, 1)));
      foreach (pool[i]) pool[i] = $urandom;
      t = {16'($urandom_range(16'hFF00)), $urandom};
      for (int i = 0; i < 40; i++) begin
        if ($urandom_range(99) < 3) t = t - 48'($urandom_range(800));
        else t = t + 48'($urandom_range(700));
        send_req(($urandom_range(9) == 0) ? $urandom : pool[$urandom_range(5)], t);
      end
      drain();
    end

    // Many distinct live clients fill the table.
    idle_pct = 10;
    stall_pct = 10;
    write_reg(CFG_MAX_REQUESTS, 12'd4);
    write_reg(CFG_WINDOW_SECONDS, 12'd60);
    t = 48'd90000000;
    for (int i = 0; i < 70; i++) send_req($urandom, t + 48'(i));
    send_req(32'hDEAD_BEEF, t + 48'd200000);
    drain();

    // Receiver held off while requests keep coming, so the input backs up.
    rx_hold = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    for (int i = 0; i < 20; i++) send_req(pool[i % 3], t + 48'd300000 + 48'(i * 50));
    drain();

    // One client with the ring at full depth, then the ring wrapping around.
    idle_pct = 0;
    stall_pct = 0;
    write_reg(CFG_MAX_REQUESTS, 12'd255);
    write_reg(CFG_WINDOW_SECONDS, 12'd3600);
    t = 48'd500000000;
    for (int i = 0; i < 130; i++) send_req(32'h0BAD_F00D, t);
    drain();
    write_reg(CFG_MAX_REQUESTS, 12'd128);
    write_reg(CFG_WINDOW_SECONDS, 12'd1);
    t = t + 48'd10000000;
    for (int i = 0; i < 60; i++) begin
      t = t + 48'($urandom_range(40, 5));
      send_req(32'h0BAD_F00D, t);
    end
    drain();

    $display("Covered %0d requests: %0d admitted, %0d rate limited, %0d table full,",
             n_req, n_allowed, n_limited, n_full);
    $display("across register extremes, idle/stall mixes and a long receiver hold-off.");
    if (errors == 0)
      $display("sliding_log_rate_limiter_core verification clean");
    else
      $display("sliding_log_rate_limiter_core verification failed");
    $finish;
  end

endmodule
